// ===== rtl/lsdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Local standard deviation filter package
// Shared constants, register indexes and widths of the filter.
// ----------------------------------------------------------------------------
package lsdf_pkg;

  localparam int MaxHalf   = 7;
  localparam int MaxWidth  = 1024;
  localparam int Lines     = 2 * MaxHalf + 1;
  localparam int LineDepth = Lines * MaxWidth;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int ColW      = $clog2(MaxWidth);
  localparam int SlotW     = $clog2(Lines);
  localparam int RowW      = 17;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CfgWindowWidth  = 3'd0;
  localparam cfg_idx_t CfgWindowHeight = 3'd1;
  localparam cfg_idx_t CfgImageWidth   = 3'd2;
  localparam cfg_idx_t CfgImageHeight  = 3'd3;

endpackage
`default_nettype wire

// ===== rtl/lsdf_div_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Divide and square root unit
// Restoring division of the scaled variance by N squared, then a bit-wise
// floor square root of the quotient.
// ----------------------------------------------------------------------------
module lsdf_div_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [6:0]       root_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StSqrt
  } state_e;

  state_e      state_q;
  logic [4:0]  cnt_q;
  logic [16:0] rem_q;
  logic [31:0] quo_q;
  logic [15:0] den_q;
  logic [7:0]  root_q;
  logic [2:0]  bit_q;

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  assign rem_sh   = {rem_q[15:0], quo_q[31]};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign trial    = root_q | (8'd1 << bit_q);
  assign trial_sq = trial * trial;
  assign root_o   = root_q[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o  <= 1'b0;
      cnt_q   <= '0;
      bit_q   <= '0;
      root_q  <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            quo_q   <= num_i;
            den_q   <= den_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sub;
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            root_q  <= '0;
            bit_q   <= 3'd7;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          // The variance of bytes stays below 2^14, so eight root bits do.
          if (trial_sq <= {1'b0, quo_q[14:0]}) begin
            root_q <= trial;
          end
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            done_o  <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/local_standard_deviation_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Local standard deviation filter
// Raster-order sliding-window standard deviation of 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are kept in a line store of fifteen rows.
// For each image position the block gives the floor square root of the
// variance over a window centred on it and clipped to the image; N is the
// pixel count inside the clipped window. Results for row y come with the
// requests of row y plus the half height, and the host ends each frame with
// half-height rows of pad requests. A request that causes no result goes
// through accept, store of its pixel and advance of the frame position. Each
// result it causes (at most half width plus one) then reads the window pixel
// by pixel through the single memory port, followed by a setup state, the
// multiply states StMulA and StMulB, restoring division, square root, the
// handoff to and from the unit and an output state that holds until the result
// is taken; the line store read port dominates for large windows. The block
// takes no new request until all results of the current one are delivered.
// Writing a known configuration register restarts the frame position.
module local_standard_deviation_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  pixel_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       deviation_o,
  output logic             end_of_row_o,
  output logic             end_of_frame_o,
  output logic             last_of_run_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int ColW  = lsdf_pkg::ColW;
  localparam int SlotW = lsdf_pkg::SlotW;
  localparam int RowW  = lsdf_pkg::RowW;
  localparam int AddrW = lsdf_pkg::AddrW;

  typedef enum logic [3:0] {
    StIdle,
    StSetup,
    StXStart,
    StRead,
    StAcc,
    StMulA,
    StMulB,
    StCalc,
    StOut,
    StAdvance
  } state_e;

  state_e            state_q;
  logic [3:0]        win_w_q;
  logic [3:0]        win_h_q;
  logic [10:0]       img_w_q;
  logic [15:0]       img_h_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [SlotW-1:0]  slot_q;
  logic              cmd_q;
  logic [7:0]        pix_q;

  logic [15:0]       y_q;
  logic [3:0]        ny_q;
  logic [SlotW-1:0]  slot0_q;
  logic [ColW-1:0]   x_q;
  logic [ColW-1:0]   last_q;
  logic [ColW-1:0]   x0_q;
  logic [ColW-1:0]   xx_q;
  logic [3:0]        nx_q;
  logic [3:0]        ix_q;
  logic [3:0]        iy_q;
  logic [SlotW-1:0]  rslot_q;
  logic [7:0]        n_q;
  logic [15:0]       s1_q;
  logic [23:0]       s2_q;
  logic [31:0]       prod_q;
  logic [31:0]       num_q;
  logic [15:0]       den_q;
  logic              start_q;
  logic [7:0]        rdata_q;

  logic [7:0]        line_mem [lsdf_pkg::LineDepth];

  logic [10:0]       w;
  logic [ColW-1:0]   wm1;
  logic [15:0]       h;
  logic [2:0]        hx;
  logic [2:0]        hy;
  logic              in_image;
  logic              row_end;
  logic              has_out;
  logic [15:0]       y_cur;
  logic [15:0]       y0;
  logic [15:0]       y1;
  logic [4:0]        slot_diff;
  logic [ColW-1:0]   x0;
  logic [ColW-1:0]   x1;
  logic [10:0]       x_plus;
  logic [9:0]        n_full;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic              unit_done;
  logic [6:0]        unit_root;
  logic [RowW-1:0]   row_inc;

  // Effective image sizes and half window sizes.
  always_comb begin
    if (img_w_q == 11'd0) begin
      w = 11'd1;
    end else if (img_w_q > 11'(lsdf_pkg::MaxWidth)) begin
      w = 11'(lsdf_pkg::MaxWidth);
    end else begin
      w = img_w_q;
    end
  end

  assign wm1 = ColW'(w - 11'd1);
  assign h   = (img_h_q == 16'd0) ? 16'd1 : img_h_q;
  assign hx  = win_w_q[3:1];
  assign hy  = win_h_q[3:1];

  assign in_image = row_q < {1'b0, h};
  assign row_end  = col_q == wm1;
  assign has_out  = (row_q >= RowW'(hy)) && ((col_q >= ColW'(hx)) || row_end);

  // Vertical extent of the clipped window for the row whose results are due.
  assign y_cur = 16'(row_q - RowW'(hy));
  assign y0    = (y_cur >= 16'(hy)) ? y_cur - 16'(hy) : 16'd0;
  assign y1    = ({1'b0, y_cur} + 17'(hy) < {1'b0, h}) ? y_cur + 16'(hy) : h - 16'd1;

  // Line store slot of the window's top row; it lies 2*hy rows above.
  assign slot_diff = {1'b0, slot_q} - {1'b0, hy, 1'b0};

  // Horizontal extent of the clipped window for the current result.
  assign x0     = (x_q >= ColW'(hx)) ? x_q - ColW'(hx) : '0;
  assign x_plus = {1'b0, x_q} + 11'(hx);
  assign x1     = (x_plus < w) ? ColW'(x_plus) : wm1;
  assign n_full = ({1'b0, ny_q} + 5'd1) * ({1'b0, 4'(x1 - x0)} + 5'd1);

  assign rd_addr = {rslot_q, xx_q};
  assign wr_addr = {slot_q, col_q};
  assign row_inc = row_q + RowW'(1);

  assign in_ready_o  = state_q == StIdle;
  assign cfg_ready_o = 1'b1;

  // Line store: one write port for the arriving pixel, one registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == StSetup && in_image) begin
      line_mem[wr_addr] <= cmd_q ? 8'd0 : pix_q;
    end
    if (state_q == StRead) begin
      rdata_q <= line_mem[rd_addr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      win_w_q        <= 4'd3;
      win_h_q        <= 4'd3;
      img_w_q        <= 11'd1024;
      img_h_q        <= 16'd1024;
      row_q          <= '0;
      col_q          <= '0;
      slot_q         <= '0;
      start_q        <= 1'b0;
      out_valid_o    <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            pix_q   <= pixel_value_i;
            state_q <= StSetup;
          end
        end
        StSetup: begin
          if (has_out) begin
            y_q     <= y_cur;
            ny_q    <= 4'(y1 - y0);
            slot0_q <= (y_cur >= 16'(hy))
                     ? (slot_diff[4] ? SlotW'(slot_diff + 5'(lsdf_pkg::Lines))
                                     : SlotW'(slot_diff))
                     : '0;
            x_q     <= (col_q >= ColW'(hx)) ? col_q - ColW'(hx) : '0;
            last_q  <= row_end ? wm1 : col_q - ColW'(hx);
            state_q <= StXStart;
          end else begin
            state_q <= StAdvance;
          end
        end
        StXStart: begin
          x0_q    <= x0;
          xx_q    <= x0;
          nx_q    <= 4'(x1 - x0);
          ix_q    <= '0;
          iy_q    <= '0;
          rslot_q <= slot0_q;
          n_q     <= n_full[7:0];
          s1_q    <= '0;
          s2_q    <= '0;
          state_q <= StRead;
        end
        StRead: begin
          state_q <= StAcc;
        end
        StAcc: begin
          s1_q <= s1_q + 16'(rdata_q);
          s2_q <= s2_q + 24'(rdata_q * rdata_q);
          if (ix_q == nx_q) begin
            ix_q <= '0;
            xx_q <= x0_q;
            if (iy_q == ny_q) begin
              state_q <= StMulA;
            end else begin
              iy_q    <= iy_q + 4'd1;
              rslot_q <= (rslot_q == SlotW'(lsdf_pkg::Lines - 1))
                       ? '0 : rslot_q + SlotW'(1);
              state_q <= StRead;
            end
          end else begin
            ix_q    <= ix_q + 4'd1;
            xx_q    <= xx_q + ColW'(1);
            state_q <= StRead;
          end
        end
        StMulA: begin
          prod_q  <= 32'(n_q * s2_q);
          den_q   <= 16'(n_q * n_q);
          state_q <= StMulB;
        end
        StMulB: begin
          num_q   <= prod_q - 32'(s1_q * s1_q);
          start_q <= 1'b1;
          state_q <= StCalc;
        end
        StCalc: begin
          if (unit_done) begin
            deviation_o    <= unit_root;
            end_of_row_o   <= x_q == wm1;
            end_of_frame_o <= (x_q == wm1) && (y_q == h - 16'd1);
            last_of_run_o  <= x_q == last_q;
            out_valid_o    <= 1'b1;
            state_q        <= StOut;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (x_q == last_q) begin
              state_q <= StAdvance;
            end else begin
              x_q     <= x_q + ColW'(1);
              state_q <= StXStart;
            end
          end
        end
        StAdvance: begin
          if (row_end) begin
            col_q <= '0;
            if (row_inc >= RowW'(h) + RowW'(hy)) begin
              row_q  <= '0;
              slot_q <= '0;
            end else begin
              row_q  <= row_inc;
              slot_q <= (slot_q == SlotW'(lsdf_pkg::Lines - 1))
                      ? '0 : slot_q + SlotW'(1);
            end
          end else begin
            col_q <= col_q + ColW'(1);
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase

      // Register writes restart the frame; unknown indexes are ignored.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lsdf_pkg::CfgWindowWidth: begin
            win_w_q <= cfg_data_i[3:0];
            row_q   <= '0;
            col_q   <= '0;
            slot_q  <= '0;
          end
          lsdf_pkg::CfgWindowHeight: begin
            win_h_q <= cfg_data_i[3:0];
            row_q   <= '0;
            col_q   <= '0;
            slot_q  <= '0;
          end
          lsdf_pkg::CfgImageWidth: begin
            img_w_q <= cfg_data_i[10:0];
            row_q   <= '0;
            col_q   <= '0;
            slot_q  <= '0;
          end
          lsdf_pkg::CfgImageHeight: begin
            img_h_q <= cfg_data_i;
            row_q   <= '0;
            col_q   <= '0;
            slot_q  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  lsdf_div_sqrt u_div_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (unit_done),
    .root_o  (unit_root)
  );

endmodule
`default_nettype wire

// ===== test/local_standard_deviation_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local standard deviation filter testbench
// Streams small frames through the filter under many window and image sizes
// and compares every result with a cycle-free software prediction.
// ----------------------------------------------------------------------------
// Each accepted request is fed to a predictor that keeps its own line store,
// frame position and register copy. The predictor pushes the expected results
// into a queue, and a checker process pops that queue for every result the
// block delivers. Both handshakes stall at random. One test holds the result
// side off for a long stretch so that the block backs up into its input.
module local_standard_deviation_filter_tb;

  localparam int                 WatchdogLimit = 20000;
  localparam int                 SettleCycles  = 80;
  localparam int                 IdlePercent   = 27;
  localparam lsdf_pkg::cfg_idx_t CfgSpareLow   = 3'd4;
  localparam lsdf_pkg::cfg_idx_t CfgSpareHigh  = 3'd7;
  localparam logic               CmdPixel      = 1'b0;
  localparam logic               CmdPad        = 1'b1;

  typedef struct packed {
    logic [6:0] deviation;
    logic       end_of_row;
    logic       end_of_frame;
    logic       last_of_run;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  pixel_value = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  deviation;
  logic        end_of_row;
  logic        end_of_frame;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  local_standard_deviation_filter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .pixel_value_i  (pixel_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .deviation_o    (deviation),
    .end_of_row_o   (end_of_row),
    .end_of_frame_o (end_of_frame),
    .last_of_run_o  (last_of_run),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: register copies, frame position and its own line store.
  logic [3:0]  win_w_reg;
  logic [3:0]  win_h_reg;
  logic [10:0] img_w_reg;
  logic [15:0] img_h_reg;
  int          row_pos;
  int          col_pos;
  logic [7:0]  pixel_rows [lsdf_pkg::Lines * lsdf_pkg::MaxWidth];

  result_t     deviation_q [$];
  int          mismatches;
  int          results_seen;
  int          requests_sent;
  int          frames_done;

  // Idling control shared by the stimulus and the result side.
  bit          calm;
  int          hold_token;

  function automatic int eff_img_w();
    if (img_w_reg == 0) return 1;
    if (img_w_reg > lsdf_pkg::MaxWidth) return lsdf_pkg::MaxWidth;
    return img_w_reg;
  endfunction

  function automatic int eff_img_h();
    return (img_h_reg == 0) ? 1 : img_h_reg;
  endfunction

  function automatic int half_size(logic [3:0] size);
    int h;
    h = size / 2;
    return (h > lsdf_pkg::MaxHalf) ? lsdf_pkg::MaxHalf : h;
  endfunction

  function automatic logic [6:0] window_deviation(int y, int x, int w, int h, int hx, int hy);
    int     y0, y1, x0, x1;
    longint s1, s2, n, var_q, root, trial;
    s1 = 0;
    s2 = 0;
    y0 = (y >= hy) ? y - hy : 0;
    y1 = (y + hy < h) ? y + hy : h - 1;
    x0 = (x >= hx) ? x - hx : 0;
    x1 = (x + hx < w) ? x + hx : w - 1;
    for (int yy = y0; yy <= y1; yy++) begin
      for (int xx = x0; xx <= x1; xx++) begin
        longint p;
        p = pixel_rows[(yy % lsdf_pkg::Lines) * lsdf_pkg::MaxWidth + xx];
        s1 += p;
        s2 += p * p;
      end
    end
    n = (y1 - y0 + 1) * (x1 - x0 + 1);
    var_q = (n * s2 - s1 * s1) / (n * n);
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= var_q) root = trial;
    end
    return root[6:0];
  endfunction

  // Works out the results one accepted request causes and queues them.
  function automatic void predict_request(logic cmd, logic [7:0] pix);
    int w, h, hx, hy, first, last;
    bit row_end;
    result_t res;
    w = eff_img_w();
    h = eff_img_h();
    hx = half_size(win_w_reg);
    hy = half_size(win_h_reg);
    // The position, not the command, decides whether a row stores a pixel.
    if (row_pos < h) begin
      pixel_rows[(row_pos % lsdf_pkg::Lines) * lsdf_pkg::MaxWidth + col_pos] = cmd ? 8'd0 : pix;
    end
    if (row_pos >= hy) begin
      row_end = (col_pos == w - 1);
      if (col_pos >= hx || row_end) begin
        first = (col_pos >= hx) ? col_pos - hx : 0;
        last = row_end ? w - 1 : col_pos - hx;
        for (int x = first; x <= last; x++) begin
          res.deviation = window_deviation(row_pos - hy, x, w, h, hx, hy);
          res.end_of_row = (x == w - 1);
          res.end_of_frame = (x == w - 1) && (row_pos - hy == h - 1);
          res.last_of_run = (x == last);
          deviation_q.push_back(res);
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h + hy) begin
        row_pos = 0;
        frames_done++;
      end
    end
  endfunction

  function automatic void predict_config(lsdf_pkg::cfg_idx_t idx, logic [15:0] data);
    case (idx)
      lsdf_pkg::CfgWindowWidth: win_w_reg = data[3:0];
      lsdf_pkg::CfgWindowHeight: win_h_reg = data[3:0];
      lsdf_pkg::CfgImageWidth: img_w_reg = data[10:0];
      lsdf_pkg::CfgImageHeight: img_h_reg = data[15:0];
      default: return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic int idle_cycles();
    int n;
    n = 0;
    if (calm) return 0;
    while ($urandom_range(99) < IdlePercent) n++;
    return n;
  endfunction

  // Result side: checks each delivered result, then decides on ready.
  // A long hold-off starts whenever the test bumps hold_token.
  int hold_seen;
  int hold_left;
  always @(posedge clk_i) begin
    result_t got;
    result_t exp_res;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{deviation, end_of_row, end_of_frame, last_of_run};
        if (deviation_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p with nothing queued", got);
        end else begin
          exp_res = deviation_q.pop_front();
          if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result mismatch: expected %p, got %p", exp_res, got);
            end
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Watchdog: counts cycles in which no handshake of any channel completes.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results outstanding", deviation_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one request; valid stays high across back-to-back requests.
  task automatic send_request(logic cmd, logic [7:0] pix);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command <= cmd;
    pixel_value <= pix;
    do @(posedge clk_i); while (!in_ready);
    predict_request(cmd, pix);
    requests_sent++;
  endtask

  // Stops offering requests and waits until every expected result is in.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (deviation_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(lsdf_pkg::cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    predict_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int ww, int wh, int iw, int ih);
    wait_drained();
    write_reg(lsdf_pkg::CfgWindowWidth, 16'(ww));
    write_reg(lsdf_pkg::CfgWindowHeight, 16'(wh));
    write_reg(lsdf_pkg::CfgImageWidth, 16'(iw));
    write_reg(lsdf_pkg::CfgImageHeight, 16'(ih));
  endtask

  // Sends one frame, or its first `count` requests; pads close the frame.
  task automatic send_frame(int count, int noise_pct);
    int total;
    logic cmd;
    logic [7:0] pix;
    total = eff_img_w() * (eff_img_h() + half_size(win_h_reg));
    if (count > total) count = total;
    for (int i = 0; i < count; i++) begin
      cmd = (row_pos < eff_img_h()) ? CmdPixel : CmdPad;
      if ($urandom_range(99) < noise_pct) cmd = ~cmd;
      case ($urandom_range(9))
        0: pix = 8'd0;
        1: pix = 8'd255;
        default: pix = 8'($urandom);
      endcase
      send_request(cmd, pix);
    end
  endtask

  // Defaults give a huge frame; a few first-row requests cause no result.
  task automatic test_reset_defaults();
    send_request(CmdPixel, 8'd0);
    send_request(CmdPixel, 8'd255);
    send_request(CmdPad, 8'd255);
  endtask

  task automatic test_directed_corners();
    // A one-pixel image with a one-pixel window.
    set_geometry(0, 0, 1, 1);
    send_request(CmdPixel, 8'd255);
    // Even window sizes round up; pads inside the image store zero and
    // pixels sent in pad rows are dropped.
    set_geometry(2, 2, 3, 2);
    send_request(CmdPixel, 8'd0);
    send_request(CmdPixel, 8'd255);
    send_request(CmdPixel, 8'd255);
    send_request(CmdPixel, 8'd255);
    send_request(CmdPad, 8'd77);
    send_request(CmdPixel, 8'd0);
    send_request(CmdPad, 8'd0);
    send_request(CmdPixel, 8'd200);
    send_request(CmdPad, 8'd0);
    // Oversized windows clamp to the maximum half size; zero image sizes act
    // as one.
    set_geometry(15, 15, 0, 0);
    send_request(CmdPixel, 8'd255);
    for (int i = 0; i < 7; i++) send_request(logic'(i[0]), 8'd255);
    // Width beyond the maximum clamps; the tallest height. The frame is cut
    // short by the next register write.
    set_geometry(0, 0, 2000, 65535);
    write_reg(CfgSpareLow, 16'hFFFF);
    write_reg(CfgSpareHigh, 16'h0000);
    send_request(CmdPixel, 8'd1);
    send_request(CmdPixel, 8'd254);
    send_request(CmdPad, 8'd0);
  endtask

  task automatic test_random_frames();
    int sent_at_start, ww, wh, iw, ih, frame_no;
    sent_at_start = requests_sent;
    frame_no = 0;
    while (requests_sent - sent_at_start < 110) begin
      ww = ($urandom_range(9) < 7) ? $urandom_range(0, 5) : $urandom_range(0, 15);
      wh = ($urandom_range(9) < 7) ? $urandom_range(0, 5) : $urandom_range(0, 15);
      iw = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
      ih = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
      if ($urandom_range(9) == 0) iw = $urandom_range(9, 12);
      set_geometry(ww, wh, iw, ih);
      // A few frames in the middle run with no idling on either side.
      calm = (frame_no >= 3 && frame_no < 6);
      if ($urandom_range(9) == 0) send_frame($urandom_range(1, 20), 10);
      else send_frame(1 << 30, ($urandom_range(3) == 0) ? 15 : 0);
      calm = 1'b0;
      frame_no++;
    end
  endtask

  // The result side stops for a long stretch while requests keep coming, so
  // the block fills and stalls its input; then the sender waits for drain.
  task automatic test_back_pressure();
    set_geometry(4, 2, 6, 3);
    hold_token++;
    send_frame(1 << 30, 0);
    wait_drained();
  endtask

  initial begin
    win_w_reg = 4'd3;
    win_h_reg = 4'd3;
    img_w_reg = 11'd1024;
    img_h_reg = 16'd1024;
    row_pos = 0;
    col_pos = 0;
    foreach (pixel_rows[i]) pixel_rows[i] = 8'd0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    frames_done = 0;
    calm = 1'b0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_corners();
    test_back_pressure();
    test_random_frames();
    wait_drained();
    repeat (200) @(posedge clk_i);

    $display("Sent %0d requests over %0d complete frames, checked %0d results.",
             requests_sent, frames_done, results_seen);
    $display("Covered clamped sizes, pad handling, truncated frames and long stalls.");
    if (mismatches == 0 && deviation_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, deviation_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
